/* rtl/core/cglc_pkg.sv */
// shared types and constants for the click gesture lock control block
`timescale 1ns / 1ps

package cglc_pkg;

  localparam int unsigned CntW = 10;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};
  localparam logic [CntW-1:0] LONG_PRESS_RESET = 10'd200;
  localparam logic [CntW-1:0] CLICK_WINDOW_RESET = 10'd40;

  // register index, taken from paddr bit 2
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_CLICK_WINDOW = 1'b1;

  localparam logic [1:0] CLICKS_ONE = 2'd1;
  localparam logic [1:0] CLICKS_TWO = 2'd2;
  localparam logic [1:0] CLICKS_SAT = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LOCK   = 2'd1,
    EV_UNLOCK = 2'd2,
    EV_ALARM  = 2'd3
  } event_e;

  typedef struct packed {
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] click_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic            lock_flag;
    logic            held_flag;
    logic            long_fired;
    logic [CntW-1:0] hold_ticks;
    logic [1:0]      click_total;
    logic [CntW-1:0] window_ticks;
  } state_t;

  typedef struct packed {
    logic       locked;
    event_e     event_code;
    logic [1:0] beep_count;
  } result_t;

endpackage

/* rtl/core/cglc_regs.sv */
// apb configuration registers for the gesture decoder
`timescale 1ns / 1ps

module cglc_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cglc_pkg::AddrW-1:0]       paddr,
  input  logic [cglc_pkg::DataW-1:0]       pwdata,
  output logic [cglc_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  output cglc_pkg::cfg_t                   cfg_o
);

  cglc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == cglc_pkg::REG_LONG_PRESS) begin
        cfg_d.long_press_ticks = pwdata[cglc_pkg::CntW-1:0];
      end else begin
        cfg_d.click_window_ticks = pwdata[cglc_pkg::CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= cglc_pkg::LONG_PRESS_RESET;
      cfg_q.click_window_ticks <= cglc_pkg::CLICK_WINDOW_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cglc_pkg::REG_CLICK_WINDOW) begin
      prdata[cglc_pkg::CntW-1:0] = cfg_q.click_window_ticks;
    end else begin
      prdata[cglc_pkg::CntW-1:0] = cfg_q.long_press_ticks;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/cglc_step.sv */
// gesture state registers and the per-tick next-state logic
`timescale 1ns / 1ps

module cglc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                pressed_i,
  input  cglc_pkg::cfg_t      cfg_i,
  output cglc_pkg::result_t   res_o
);

  cglc_pkg::state_t st_q, st_d;
  cglc_pkg::event_e ev;

  always_comb begin
    st_d = st_q;
    ev   = cglc_pkg::EV_NONE;

    if (pressed_i) begin
      if (!st_d.held_flag) begin
        st_d.held_flag  = 1'b1;
        st_d.hold_ticks = '0;
      end
      if ((st_d.hold_ticks < cfg_i.long_press_ticks) && (st_d.hold_ticks != cglc_pkg::CNT_MAX)) begin
        st_d.hold_ticks = st_d.hold_ticks + 1'b1;
      end
      if ((st_d.hold_ticks >= cfg_i.long_press_ticks) && !st_d.long_fired) begin
        ev                = cglc_pkg::EV_ALARM;
        st_d.long_fired   = 1'b1;
        st_d.click_total  = '0;
        st_d.window_ticks = '0;
      end
    end else begin
      if (st_d.held_flag) begin
        if (!st_d.long_fired) begin
          if (st_d.click_total != cglc_pkg::CLICKS_SAT) begin
            st_d.click_total = st_d.click_total + 1'b1;
          end
          st_d.window_ticks = '0;
        end else begin
          st_d.long_fired = 1'b0;
        end
      end
      st_d.held_flag  = 1'b0;
      st_d.hold_ticks = '0;
    end

    // click window runs after the press/release handling, also while held
    if (st_d.click_total != '0) begin
      if (st_d.window_ticks != cglc_pkg::CNT_MAX) begin
        st_d.window_ticks = st_d.window_ticks + 1'b1;
      end
      if (st_d.window_ticks >= cfg_i.click_window_ticks) begin
        if ((st_d.click_total == cglc_pkg::CLICKS_ONE) && !st_d.lock_flag) begin
          st_d.lock_flag = 1'b1;
          ev             = cglc_pkg::EV_LOCK;
        end else if ((st_d.click_total == cglc_pkg::CLICKS_TWO) && st_d.lock_flag) begin
          st_d.lock_flag = 1'b0;
          ev             = cglc_pkg::EV_UNLOCK;
        end
        st_d.click_total  = '0;
        st_d.window_ticks = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.lock_flag    <= 1'b1;
      st_q.held_flag    <= 1'b0;
      st_q.long_fired   <= 1'b0;
      st_q.hold_ticks   <= '0;
      st_q.click_total  <= '0;
      st_q.window_ticks <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  // beep count equals the event code: lock 1, unlock 2, alarm 3
  always_comb begin
    res_o.locked     = st_d.lock_flag;
    res_o.event_code = ev;
    res_o.beep_count = ev;
  end

endmodule

/* rtl/core/click_gesture_lock_control.sv */
// click gesture lock control: single/double click and long press decoder
// path from input transaction to result: input register, then result register
// throughput: one transaction per cycle unless out_ready_i stalls it, set by the state update
// while a result waits for out_ready_i the input register holds one more transaction
// reset (rst_ni low, async): locked, no clicks pending, registers 200 and 40
`timescale 1ns / 1ps

module click_gesture_lock_control (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         pressed_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         locked_o,
  output logic [1:0]                   event_code_o,
  output logic [1:0]                   beep_count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cglc_pkg::AddrW-1:0]   paddr,
  input  logic [cglc_pkg::DataW-1:0]   pwdata,
  output logic [cglc_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  cglc_pkg::cfg_t    cfg;
  cglc_pkg::result_t res;
  cglc_pkg::result_t out_q;
  logic              in_valid_q;
  logic              pressed_q;
  logic              out_valid_q;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cglc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cglc_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .pressed_i (pressed_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pressed_q <= pressed_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign locked_o     = out_q.locked;
  assign event_code_o = out_q.event_code;
  assign beep_count_o = out_q.beep_count;

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after a step");

  a_lock_event_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == cglc_pkg::EV_LOCK) |-> locked_o)
    else $error("lock event with lock state clear");

  a_unlock_event_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == cglc_pkg::EV_UNLOCK) |-> !locked_o)
    else $error("unlock event with lock state set");

  a_no_event_no_beep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == cglc_pkg::EV_NONE) |-> (beep_count_o == 2'd0))
    else $error("beeps requested without an event");

endmodule

/* test/tb_click_gesture_lock_control.sv */
// testbench for the click gesture lock control block with a self-checking gesture tracker
`timescale 1ns / 1ps

module tb_click_gesture_lock_control;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned RandomItems = 150;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           pressed_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           locked_o;
  logic [1:0]                     event_code_o;
  logic [1:0]                     beep_count_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cglc_pkg::AddrW-1:0]     paddr = '0;
  logic [cglc_pkg::DataW-1:0]     pwdata = '0;
  logic [cglc_pkg::DataW-1:0]     prdata;
  logic                           pready;

  click_gesture_lock_control uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pressed_i   (pressed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .locked_o    (locked_o),
    .event_code_o(event_code_o),
    .beep_count_o(beep_count_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  class gesture_lock_tracker;
    logic [cglc_pkg::CntW-1:0] long_press;
    logic [cglc_pkg::CntW-1:0] click_window;
    logic                      lock_flag;
    logic                      held;
    logic                      long_fired;
    logic [cglc_pkg::CntW-1:0] hold_cnt;
    logic [1:0]                clicks;
    logic [cglc_pkg::CntW-1:0] win_cnt;
    cglc_pkg::result_t         lock_reports_q[$];
    int                        errors;

    function new();
      long_press = cglc_pkg::LONG_PRESS_RESET;
      click_window = cglc_pkg::CLICK_WINDOW_RESET;
      lock_flag = 1'b1;
      held = 1'b0;
      long_fired = 1'b0;
      hold_cnt = '0;
      clicks = '0;
      win_cnt = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [cglc_pkg::CntW-1:0] value);
      if (idx == cglc_pkg::REG_LONG_PRESS) begin
        long_press = value;
      end else begin
        click_window = value;
      end
    endfunction

    function void note_press(logic pressed);
      cglc_pkg::result_t r;
      cglc_pkg::event_e  ev;
      logic [1:0]        beeps;
      ev = cglc_pkg::EV_NONE;
      beeps = 2'd0;
      if (pressed) begin
        if (!held) begin
          held = 1'b1;
          hold_cnt = '0;
        end
        if (hold_cnt < long_press && hold_cnt != cglc_pkg::CNT_MAX) hold_cnt++;
        if (hold_cnt >= long_press && !long_fired) begin
          ev = cglc_pkg::EV_ALARM;
          beeps = 2'd3;
          long_fired = 1'b1;
          clicks = '0;
          win_cnt = '0;
        end
      end else begin
        if (held) begin
          if (!long_fired) begin
            if (clicks != cglc_pkg::CLICKS_SAT) clicks++;
            win_cnt = '0;
          end else begin
            long_fired = 1'b0;
          end
        end
        held = 1'b0;
        hold_cnt = '0;
      end
      // window keeps running while the button is held
      if (clicks != 2'd0) begin
        if (win_cnt != cglc_pkg::CNT_MAX) win_cnt++;
        if (win_cnt >= click_window) begin
          if (clicks == cglc_pkg::CLICKS_ONE && !lock_flag) begin
            lock_flag = 1'b1;
            ev = cglc_pkg::EV_LOCK;
            beeps = 2'd1;
          end else if (clicks == cglc_pkg::CLICKS_TWO && lock_flag) begin
            lock_flag = 1'b0;
            ev = cglc_pkg::EV_UNLOCK;
            beeps = 2'd2;
          end
          clicks = '0;
          win_cnt = '0;
        end
      end
      r.locked = lock_flag;
      r.event_code = ev;
      r.beep_count = beeps;
      lock_reports_q.push_back(r);
    endfunction

    function void check_result(cglc_pkg::result_t got);
      cglc_pkg::result_t want;
      if (lock_reports_q.size() == 0) begin
        $error("unexpected result: locked=%0b event_code=%0d beep_count=%0d",
               got.locked, got.event_code, got.beep_count);
        errors++;
        return;
      end
      want = lock_reports_q.pop_front();
      if (got.locked !== want.locked) begin
        $error("locked: expected %0b, got %0b", want.locked, got.locked);
        errors++;
      end
      if (got.event_code !== want.event_code) begin
        $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
        errors++;
      end
      if (got.beep_count !== want.beep_count) begin
        $error("beep_count: expected %0d, got %0d", want.beep_count, got.beep_count);
        errors++;
      end
    endfunction

    function int pending();
      return lock_reports_q.size();
    endfunction
  endclass

  gesture_lock_tracker tracker = new();

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_off_req = 1'b0;
  int stall_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // both channels observed at the rising edge
  always @(posedge clk_i) begin
    cglc_pkg::result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.note_press(pressed_i);
      if (out_valid_o && out_ready_i) begin
        got.locked = locked_o;
        got.event_code = cglc_pkg::event_e'(event_code_o);
        got.beep_count = beep_count_o;
        tracker.check_result(got);
        stall_left = recv_idle ? $urandom_range(0, 5) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("click_gesture_lock_control verification failed");
          $finish;
        end
      end
    end
  end

  // result side backpressure, including one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = 250;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(logic p);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pressed_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic press_run(int n);
    repeat (n) send_item(1'b1);
  endtask

  task automatic release_run(int n);
    repeat (n) send_item(1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic idx, logic [cglc_pkg::CntW-1:0] value);
    logic [cglc_pkg::DataW-1:0] junk;
    junk = $urandom;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[cglc_pkg::DataW-1:cglc_pkg::CntW], value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(logic idx);
    logic [cglc_pkg::CntW-1:0] want;
    want = (idx == cglc_pkg::REG_LONG_PRESS) ? tracker.long_press : tracker.click_window;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[cglc_pkg::CntW-1:0] !== want) begin
      $error("prdata reg %0d: expected %0d, got %0d", idx, want,
             prdata[cglc_pkg::CntW-1:0]);
      tracker.errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_thresholds(logic [cglc_pkg::CntW-1:0] lp,
                                logic [cglc_pkg::CntW-1:0] win);
    wait_idle();
    apb_write(cglc_pkg::REG_LONG_PRESS, lp);
    apb_write(cglc_pkg::REG_CLICK_WINDOW, win);
    apb_read_check(cglc_pkg::REG_LONG_PRESS);
    apb_read_check(cglc_pkg::REG_CLICK_WINDOW);
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  // k clicks, the last one followed by a gap near the window length
  task automatic click_burst(int k);
    int short_press;
    int short_gap;
    int win;
    short_press = (tracker.long_press > 1) ?
                  ((tracker.long_press - 1 < 24) ? tracker.long_press - 1 : 24) : 1;
    short_gap = (tracker.click_window > 1) ?
                ((tracker.click_window - 1 < 20) ? tracker.click_window - 1 : 20) : 1;
    win = tracker.click_window;
    for (int i = 0; i < k; i++) begin
      press_run($urandom_range(1, short_press));
      if (i < k - 1) begin
        release_run($urandom_range(1, short_gap));
      end else begin
        release_run((win > 1 ? win - 1 : 1) + $urandom_range(0, 3));
      end
    end
  endtask

  task automatic random_gestures(int target);
    int start;
    int lp;
    start = items_sent;
    lp = tracker.long_press;
    while (items_sent - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: click_burst(1);
        3, 4:    click_burst(2);
        5:       click_burst($urandom_range(3, 5));
        6: begin
          press_run(((lp > 0) ? lp : 1) + $urandom_range(0, 3));
          release_run($urandom_range(1, 4));
        end
        7: begin
          // pending click dropped by a long press
          press_run(1);
          release_run(1);
          press_run(((lp > 0) ? lp : 1) + $urandom_range(0, 2));
          release_run($urandom_range(1, 3));
        end
        default: begin
          repeat ($urandom_range(1, 8)) send_item(1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin
    logic directed_seq[] = '{1'b1, 1'b0, 1'b0, 1'b0,
                             1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                             1'b1, 1'b0, 1'b0, 1'b0,
                             1'b1, 1'b1, 1'b1, 1'b0,
                             1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    int base;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of both registers
    apb_read_check(cglc_pkg::REG_LONG_PRESS);
    apb_read_check(cglc_pkg::REG_CLICK_WINDOW);

    // click while locked, double click, single click, long press, triple click
    set_thresholds(10'd3, 10'd3);
    foreach (directed_seq[i]) send_item(directed_seq[i]);

    set_thresholds(10'd0, 10'd0);
    random_gestures(40);
    set_thresholds(10'd0, 10'd7);
    random_gestures(40);
    set_thresholds(10'd6, 10'd0);
    random_gestures(40);

    set_thresholds(10'd1, 10'd1);
    send_idle = 1'b0;
    hold_off_req = 1'b1;
    random_gestures(100);

    set_thresholds(cglc_pkg::LONG_PRESS_RESET, cglc_pkg::CLICK_WINDOW_RESET);
    random_gestures(60);

    // both counters run to the top of their range: a double click whose
    // window expires during a hold, then the alarm at the hold limit
    set_thresholds(cglc_pkg::CNT_MAX, cglc_pkg::CNT_MAX);
    press_run(2);
    release_run(1);
    press_run(2);
    release_run(1);
    press_run(1026);
    release_run(3);

    base = items_sent;
    while (items_sent - base < RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        set_thresholds(10'($urandom_range(1, 60)), 10'($urandom_range(1, 30)));
      end else begin
        set_thresholds(10'($urandom_range(1, 16)), 10'($urandom_range(1, 12)));
      end
      random_gestures($urandom_range(80, 200));
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("click_gesture_lock_control verification clean");
    end else begin
      $display("click_gesture_lock_control verification failed");
    end
    $finish;
  end

endmodule
